[rtl/core/assert_macros.svh]
// Assertion macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/pqe_pkg.sv]
// Shared types and constants of the thick line quad expander
package pqe_pkg;
  localparam logic [15:0] SEG_CAP = 16'hFFFF;
  localparam logic [30:0] THICK_RESET = 31'd65536;

  typedef struct packed {
    logic [30:0] ax;
    logic [30:0] ay;
    logic [62:0] sum;
  } nrm_req_t;

  typedef struct packed {
    logic [16:0] ux;
    logic [16:0] uy;
  } nrm_res_t;
endpackage

[rtl/core/pqe_norm_unit.sv]
// Iterative square root and two divisions on one compare-subtract unit
module pqe_norm_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  pqe_pkg::nrm_req_t req,
  output logic              done,
  output pqe_pkg::nrm_res_t res
);
  import pqe_pkg::*;

  typedef enum logic [1:0] {N_IDLE, N_SQRT, N_DIVX, N_DIVY} phase_t;

  phase_t      phase;
  logic [4:0]  cnt;
  logic [63:0] rad;
  logic [33:0] rem;
  logic [31:0] root;
  logic [16:0] num;
  logic [16:0] quo;
  logic [30:0] ax;
  logic [30:0] ay;
  logic [35:0] sh;
  logic [35:0] trial;
  logic [35:0] diff;
  logic        ge;
  logic [33:0] rem_next;

  always_comb begin
    if (phase == N_SQRT) begin
      sh    = {rem, rad[63:62]};
      trial = {2'b00, root, 2'b01};
    end else begin
      sh    = {1'b0, rem, num[16]};
      trial = {4'b0000, root};
    end
    ge       = (sh >= trial);
    diff     = sh - trial;
    rem_next = ge ? diff[33:0] : sh[33:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= N_IDLE;
      done  <= 1'b0;
      cnt   <= '0;
    end else begin
      case (phase)
        N_IDLE: begin
          done <= 1'b0;
          if (start) begin
            rad   <= {1'b0, req.sum};
            rem   <= '0;
            root  <= '0;
            ax    <= req.ax;
            ay    <= req.ay;
            num   <= {req.ax[0], 16'd0};
            quo   <= '0;
            cnt   <= '0;
            phase <= N_SQRT;
          end
        end
        N_SQRT: begin
          root <= {root[30:0], ge};
          rad  <= {rad[61:0], 2'b00};
          cnt  <= cnt + 5'd1;
          if (cnt == 5'd31) begin
            rem   <= {4'b0000, ax[30:1]};
            phase <= N_DIVX;
          end else begin
            rem <= rem_next;
          end
        end
        N_DIVX, N_DIVY: begin
          quo <= {quo[15:0], ge};
          if (cnt == 5'd16) begin
            cnt <= '0;
            if (phase == N_DIVX) begin
              res.ux <= {quo[15:0], ge};
              rem    <= {4'b0000, ay[30:1]};
              num    <= {ay[0], 16'd0};
              phase  <= N_DIVY;
            end else begin
              res.uy <= {quo[15:0], ge};
              done   <= 1'b1;
              phase  <= N_IDLE;
            end
          end else begin
            rem <= rem_next;
            num <= {num[15:0], 1'b0};
            cnt <= cnt + 5'd1;
          end
        end
        default: phase <= N_IDLE;
      endcase
    end
  end
endmodule

[rtl/core/polyline_thick_quad_expander_core.sv]
// Top level: sequencer, shared multiplier and corner output of the quad expander
// Each vertex after the first of a polyline is normalized by a 32-step square
// root and two 17-step divisions on one compare-subtract unit, with squaring
// and scaling on one shared multiplier. A zero-length segment skips the
// normalization. Four corner words follow, one per cycle when the output is
// not stalled, and the next vertex can be accepted in the cycle after the last
// corner word. A first vertex produces no corner words and is stored unless
// it also ends the line. Input is stalled while a vertex is in work.
// Configuration must be written only while idle; the block does not enforce it.
module polyline_thick_quad_expander_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [30:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] point_x,
  input  logic [31:0] point_y,
  input  logic        end_of_line,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] corner_x,
  output logic [31:0] corner_y,
  output logic [17:0] vertex_index,
  output logic        degenerate,
  output logic        run_last
);
  import pqe_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_DIFF, S_SQX, S_SQY, S_NORM, S_SCX, S_SCY, S_EMIT
  } state_t;

  state_t      state;
  logic [30:0] thick;
  logic [31:0] px, py, cx, cy;
  logic        last, have_prev;
  logic [15:0] seg;
  logic [30:0] ax, ay;
  logic        sx, sy, degen;
  logic [62:0] sum;
  logic [16:0] umx, umy;
  logic [31:0] ox, oy;
  logic [1:0]  k;
  logic        nrm_start, nrm_done;
  nrm_req_t    nrm_req;
  nrm_res_t    nrm_res;
  logic [32:0] dx, dy, adx, ady;
  logic        big;
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic [33:0] bx, by, sxum, syum;
  logic        out_take, in_take;

  assign in_stall = (state != S_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;

  assign dx  = {cx[31], cx} - {px[31], px};
  assign dy  = {cy[31], cy} - {py[31], py};
  assign adx = dx[32] ? -dx : dx;
  assign ady = dy[32] ? -dy : dy;
  assign big = adx[32] | adx[31] | ady[32] | ady[31];

  always_comb begin
    case (state)
      S_SQX:   begin mul_a = {1'b0, ax};    mul_b = {1'b0, ax}; end
      S_SQY:   begin mul_a = {1'b0, ay};    mul_b = {1'b0, ay}; end
      S_SCX:   begin mul_a = {15'd0, umy};  mul_b = {2'b00, thick[30:1]}; end
      default: begin mul_a = {15'd0, umx};  mul_b = {2'b00, thick[30:1]}; end
    endcase
    prod = mul_a * mul_b;
  end

  assign nrm_req = '{ax: ax, ay: ay, sum: sum};

  pqe_norm_unit u_norm (
    .clk   (clk),
    .rst   (rst),
    .start (nrm_start),
    .req   (nrm_req),
    .done  (nrm_done),
    .res   (nrm_res)
  );

  always_comb begin
    bx = (k == 2'd0 || k == 2'd3) ? {{2{px[31]}}, px} : {{2{cx[31]}}, cx};
    by = (k == 2'd0 || k == 2'd3) ? {{2{py[31]}}, py} : {{2{cy[31]}}, cy};
    if (k[1]) begin
      sxum = bx + {{2{ox[31]}}, ox};
      syum = by + {{2{oy[31]}}, oy};
    end else begin
      sxum = bx - {{2{ox[31]}}, ox};
      syum = by - {{2{oy[31]}}, oy};
    end
    if (sxum[33] && !(&sxum[32:31]))       corner_x = 32'h8000_0000;
    else if (!sxum[33] && (|sxum[32:31]))  corner_x = 32'h7FFF_FFFF;
    else                                   corner_x = sxum[31:0];
    if (syum[33] && !(&syum[32:31]))       corner_y = 32'h8000_0000;
    else if (!syum[33] && (|syum[32:31]))  corner_y = 32'h7FFF_FFFF;
    else                                   corner_y = syum[31:0];
  end

  assign vertex_index = {seg, k};
  assign degenerate   = degen;
  assign run_last     = (k == 2'd3);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      thick     <= THICK_RESET;
      px        <= '0;
      py        <= '0;
      have_prev <= 1'b0;
      seg       <= '0;
      out_valid <= 1'b0;
      nrm_start <= 1'b0;
      k         <= '0;
    end else begin
      if (cfg_wr_en) thick <= cfg_wr_data;
      case (state)
        S_IDLE: begin
          if (in_take) begin
            cx   <= point_x;
            cy   <= point_y;
            last <= end_of_line;
            if (have_prev) begin
              state <= S_DIFF;
            end else if (end_of_line) begin
              px <= '0;
              py <= '0;
            end else begin
              px        <= point_x;
              py        <= point_y;
              have_prev <= 1'b1;
            end
          end
        end
        S_DIFF: begin
          ax    <= big ? adx[31:1] : adx[30:0];
          ay    <= big ? ady[31:1] : ady[30:0];
          sx    <= dx[32];
          sy    <= dy[32];
          degen <= (adx == '0) && (ady == '0);
          if ((adx == '0) && (ady == '0)) begin
            umx   <= '0;
            umy   <= '0;
            state <= S_SCX;
          end else begin
            state <= S_SQX;
          end
        end
        S_SQX: begin
          sum   <= prod[62:0];
          state <= S_SQY;
        end
        S_SQY: begin
          sum       <= sum + prod[62:0];
          nrm_start <= 1'b1;
          state     <= S_NORM;
        end
        S_NORM: begin
          nrm_start <= 1'b0;
          if (nrm_done) begin
            umx   <= nrm_res.ux;
            umy   <= nrm_res.uy;
            state <= S_SCX;
          end
        end
        S_SCX: begin
          ox    <= sy ? -{1'b0, prod[46:16]} : {1'b0, prod[46:16]};
          state <= S_SCY;
        end
        S_SCY: begin
          oy        <= sx ? {1'b0, prod[46:16]} : -{1'b0, prod[46:16]};
          k         <= '0;
          out_valid <= 1'b1;
          state     <= S_EMIT;
        end
        S_EMIT: begin
          if (out_take) begin
            k <= k + 2'd1;
            if (k == 2'd3) begin
              out_valid <= 1'b0;
              state     <= S_IDLE;
              if (last) begin
                px        <= '0;
                py        <= '0;
                have_prev <= 1'b0;
                seg       <= '0;
              end else begin
                px <= cx;
                py <= cy;
                if (seg < SEG_CAP) seg <= seg + 16'd1;
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`include "assert_macros.svh"
  `ASSERT_NOW(a_out_only_busy, out_valid, in_stall, "output word while input open")
  `ASSERT_NOW(a_last_idx, out_valid && run_last, vertex_index[1:0] == 2'd3, "run_last index")
  `ASSERT_NEXT(a_done_after, out_take && run_last, !out_valid && !in_stall, "quad end")
endmodule

[sim/polyline_thick_quad_expander_core_tb.sv]
// Testbench of the thick polyline quad expander: directed and random polylines against a predictor
module polyline_thick_quad_expander_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pqe_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE = 120;
  localparam int CFG_INDEX = 0;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [17:0] idx;
    logic        degen;
    logic        last;
  } corner_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_wr_en = 0;
  logic [30:0] cfg_wr_data = '0;
  logic in_valid = 0;
  logic in_stall;
  logic [31:0] point_x = '0;
  logic [31:0] point_y = '0;
  logic end_of_line = 0;
  logic out_valid;
  logic out_stall = 0;
  logic [31:0] corner_x;
  logic [31:0] corner_y;
  logic [17:0] vertex_index;
  logic degenerate;
  logic run_last;

  corner_t corner_q[$];
  int errors = 0;
  int cycles = 0;
  bit steady = 0;

  // predictor state
  logic [30:0] thick_m = THICK_RESET;
  longint prev_x_m = 0;
  longint prev_y_m = 0;
  bit have_prev_m = 0;
  logic [15:0] seg_m = 0;

  polyline_thick_quad_expander_core dut (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall), .point_x(point_x), .point_y(point_y),
    .end_of_line(end_of_line), .out_valid(out_valid), .out_stall(out_stall),
    .corner_x(corner_x), .corner_y(corner_y), .vertex_index(vertex_index),
    .degenerate(degenerate), .run_last(run_last)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t timeout", $time);
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic int gap_len();
    if (steady || $urandom_range(9, 0) < 6) return 0;
    if ($urandom_range(15, 0) == 0) return $urandom_range(60, 15);
    return $urandom_range(4, 1);
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned r = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint scale_half(input longint n, input longint unsigned half);
    longint unsigned mag = n < 0 ? -n : n;
    longint m = longint'((mag * half) >> 16);
    return n < 0 ? -m : m;
  endfunction

  function automatic logic [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'h7FFFFFFF;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  task automatic predict_quad(input logic [31:0] px, input logic [31:0] py, input bit eol);
    longint cx = longint'($signed(px));
    longint cy = longint'($signed(py));
    longint dx, dy, ux, uy, ox, oy;
    longint unsigned ax, ay, len, half;
    longint xs[4], ys[4];
    bit dg;
    corner_t c;
    if (have_prev_m) begin
      dx = cx - prev_x_m;
      dy = cy - prev_y_m;
      ax = dx < 0 ? -dx : dx;
      ay = dy < 0 ? -dy : dy;
      dg = (ax == 0 && ay == 0);
      ux = 0;
      uy = 0;
      if (!dg) begin
        if (ax >= 64'h80000000 || ay >= 64'h80000000) begin
          ax >>= 1;
          ay >>= 1;
        end
        len = int_sqrt(ax * ax + ay * ay);
        if (len != 0) begin
          ux = longint'((ax * 65536) / len);
          uy = longint'((ay * 65536) / len);
        end
        if (dx < 0) ux = -ux;
        if (dy < 0) uy = -uy;
      end
      half = thick_m >> 1;
      ox = scale_half(uy, half);
      oy = scale_half(-ux, half);
      xs[0] = prev_x_m - ox; ys[0] = prev_y_m - oy;
      xs[1] = cx - ox;       ys[1] = cy - oy;
      xs[2] = cx + ox;       ys[2] = cy + oy;
      xs[3] = prev_x_m + ox; ys[3] = prev_y_m + oy;
      for (int k = 0; k < 4; k++) begin
        c.x = clamp32(xs[k]);
        c.y = clamp32(ys[k]);
        c.idx = {seg_m, 2'b00} + 18'(k);
        c.degen = dg;
        c.last = (k == 3);
        corner_q = {corner_q, c};
      end
      if (seg_m != SEG_CAP) seg_m++;
    end
    if (eol) begin
      prev_x_m = 0;
      prev_y_m = 0;
      have_prev_m = 0;
      seg_m = 0;
    end else begin
      prev_x_m = cx;
      prev_y_m = cy;
      have_prev_m = 1;
    end
  endtask

  task automatic send_point(input logic [31:0] px, input logic [31:0] py, input bit eol);
    int g = gap_len();
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1;
    point_x <= px;
    point_y <= py;
    end_of_line <= eol;
    do @(posedge clk); while (in_stall);
    predict_quad(px, py, eol);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (corner_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_thickness(input logic [30:0] v);
    drain();
    cfg_wr_en <= 1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 0;
    if (CFG_INDEX == 0) thick_m = v;
    @(posedge clk);
  endtask

  // result checker and output stall generator
  always @(posedge clk) begin
    corner_t e;
    if (!rst && out_valid && !out_stall) begin
      if (corner_q.size() == 0) begin
        $display("%0t unexpected word: x=%h y=%h idx=%0d", $time, corner_x, corner_y,
                 vertex_index);
        errors++;
      end else begin
        e = corner_q.pop_front();
        if (corner_x !== e.x || corner_y !== e.y || vertex_index !== e.idx ||
            degenerate !== e.degen || run_last !== e.last) begin
          $display("%0t mismatch: exp x=%h y=%h idx=%0d dg=%b last=%b", $time,
                   e.x, e.y, e.idx, e.degen, e.last);
          $display("%0t           got x=%h y=%h idx=%0d dg=%b last=%b", $time,
                   corner_x, corner_y, vertex_index, degenerate, run_last);
          errors++;
        end
      end
    end
    if (steady || $urandom_range(9, 0) < 6) out_stall <= 0;
    else if ($urandom_range(15, 0) == 0) out_stall <= 1;
    else out_stall <= $urandom_range(1, 0);
  end

  task automatic test_directed();
    send_point(32'h0001_0000, 32'h0002_0000, 1);            // lone vertex
    send_point(32'h0, 32'h0, 0);
    send_point(32'h0003_0000, 32'h0, 0);                    // horizontal
    send_point(32'h0003_0000, 32'h0004_0000, 0);            // vertical
    send_point(32'h0003_0000, 32'h0004_0000, 0);            // zero length
    send_point(32'hFFFF_0000, 32'hFFFE_8000, 0);            // diagonal back
    send_point(32'h8000_0000, 32'h7FFF_FFFF, 0);            // huge delta
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 0);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 0);
    send_point(32'h0000_0001, 32'hFFFF_FFFF, 1);
    send_point(32'h8000_0000, 32'h8000_0000, 0);
    send_point(32'h8000_0001, 32'h8000_0000, 1);            // saturating corners
  endtask

  task automatic test_thickness();
    logic [30:0] sets[3] = '{31'd0, 31'h7FFF_FFFF, 31'd1};
    foreach (sets[i]) begin
      write_thickness(sets[i]);
      send_point(32'h7FFF_0000, 32'h0, 0);
      send_point(32'h7FFF_FFFF, 32'h0001_0000, 0);
      send_point(32'h8000_0000, 32'hFFFF_0000, 0);
      send_point(32'h8000_0000, 32'hFFFF_0000, 1);
    end
    write_thickness(THICK_RESET);
  endtask

  function automatic logic [31:0] rand_coord(input logic [31:0] base);
    case ($urandom_range(5, 0))
      0: return $urandom();
      1: return $urandom_range(1, 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
      2: return base;
      default: return base + 32'($signed($urandom_range(8 << 16, 0)) - (4 << 16));
    endcase
  endfunction

  task automatic test_random(input int n);
    logic [31:0] x, y;
    int sent = 0;
    int len;
    while (sent < n) begin
      if ($urandom_range(3, 0) == 0) steady = ~steady;
      if ($urandom_range(7, 0) == 0) write_thickness($urandom_range(1, 0) ?
                                       31'($urandom()) : 31'($urandom_range(8 << 16, 0)));
      len = $urandom_range(12, 1);
      x = $urandom();
      y = $urandom();
      for (int i = 0; i < len; i++) begin
        x = rand_coord(x);
        y = rand_coord(y);
        send_point(x, y, i == len - 1);
        sent++;
      end
    end
    steady = 0;
  endtask

  task automatic test_pause();
    send_point(32'h0010_0000, 32'h0010_0000, 0);
    send_point(32'h0012_0000, 32'h0011_0000, 0);
    in_valid <= 0;
    while (corner_q.size() != 0) @(posedge clk);
    @(posedge clk);
    send_point(32'h0013_0000, 32'h000F_0000, 1);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_directed();
    test_thickness();
    test_pause();
    test_random(280);
    drain();
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule
